/* rtl/knnhc_pkg.sv */
// ----------------------------------------------------------------------------
// knnhc_pkg
// Shared constants and types for the k-nearest-neighbor histogram classifier.
// ----------------------------------------------------------------------------
package knnhc_pkg;

    localparam int BIN_BITS      = 16;
    localparam int SQ_BITS       = 2 * BIN_BITS;
    localparam int DIST_BITS     = 43;
    localparam int K_NEIGHBOURS  = 5;
    localparam int CLASS_BITS    = 2;
    localparam int NUM_CLASSES   = 4;
    localparam int IDX_BITS      = (K_NEIGHBOURS > 1) ? $clog2(K_NEIGHBOURS) : 1;
    localparam int CNT_BITS      = $clog2(K_NEIGHBOURS + 1);
    localparam int ENTRY_BITS    = DIST_BITS + CLASS_BITS;
    localparam int FIFO_DEPTH    = 2;
    localparam int FIFO_PTR_BITS = 1;
    localparam int FIFO_CNT_BITS = 2;

    typedef logic [DIST_BITS-1:0]  dist_t;
    typedef logic [CLASS_BITS-1:0] class_t;

    localparam dist_t DIST_MAX = '1;

    // One finished training sample handed from the front end to the list engine.
    typedef struct packed {
        dist_t  distance;
        class_t label;
        logic   skip;
        logic   last;
        class_t query_class;
    } event_t;

    // One entry of the nearest list.
    typedef struct packed {
        dist_t  distance;
        class_t label;
    } entry_t;

endpackage

/* rtl/knnhc_ram.sv */
// ----------------------------------------------------------------------------
// knnhc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module knnhc_ram #(
    parameter int WIDTH     = 8,
    parameter int DEPTH     = 4,
    parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                 clk,
    input  logic                 we,
    input  logic [ADDR_BITS-1:0] waddr,
    input  logic [WIDTH-1:0]     wdata,
    input  logic                 re,
    input  logic [ADDR_BITS-1:0] raddr,
    output logic [WIDTH-1:0]     rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/knnhc_front.sv */
// ----------------------------------------------------------------------------
// knnhc_front
// Squares the bin difference, accumulates the saturating distance of one
// training sample and hands each finished sample to the event queue.
// ----------------------------------------------------------------------------
module knnhc_front (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [15:0]             query_bin,
    input  logic [15:0]             train_bin,
    input  logic [1:0]              train_class,
    input  logic [1:0]              query_class,
    input  logic                    bin_last,
    input  logic                    sample_last,
    input  logic                    skip_sample,
    output logic                    push,
    output knnhc_pkg::event_t       push_data,
    input  logic                    fifo_full
);

    logic [knnhc_pkg::BIN_BITS-1:0]  bin_q;
    logic [knnhc_pkg::BIN_BITS-1:0]  bin_t;
    logic [knnhc_pkg::BIN_BITS-1:0]  diff;
    logic [knnhc_pkg::SQ_BITS-1:0]   sq;
    logic                            accept;
    logic                            s1_adv;
    logic [knnhc_pkg::DIST_BITS:0]   sum_ext;
    knnhc_pkg::dist_t                sum_sat;

    logic                            s1_vld_reg;
    logic [knnhc_pkg::SQ_BITS-1:0]   s1_sq_reg;
    knnhc_pkg::class_t               s1_class_reg;
    knnhc_pkg::class_t               s1_qclass_reg;
    logic                            s1_bin_last_reg;
    logic                            s1_sample_last_reg;
    logic                            s1_skip_reg;
    knnhc_pkg::dist_t                sum_reg;
    knnhc_pkg::dist_t                sum_next;

    assign bin_q = query_bin[knnhc_pkg::BIN_BITS-1:0];
    assign bin_t = train_bin[knnhc_pkg::BIN_BITS-1:0];
    assign diff  = (bin_q >= bin_t) ? (bin_q - bin_t) : (bin_t - bin_q);
    assign sq    = knnhc_pkg::SQ_BITS'(diff) * knnhc_pkg::SQ_BITS'(diff);

    // Only a word that closes a sample needs room in the queue.
    assign s1_adv   = s1_vld_reg && !(s1_bin_last_reg && fifo_full);
    assign in_ready = !s1_vld_reg || s1_adv;
    assign accept   = in_valid && in_ready;

    assign sum_ext = {1'b0, sum_reg} + (knnhc_pkg::DIST_BITS + 1)'(s1_sq_reg);
    assign sum_sat = sum_ext[knnhc_pkg::DIST_BITS] ? knnhc_pkg::DIST_MAX
                                                   : sum_ext[knnhc_pkg::DIST_BITS-1:0];

    always_comb
    begin
        sum_next = sum_reg;
        if (s1_adv)
        begin
            sum_next = s1_bin_last_reg ? '0 : sum_sat;
        end
    end

    assign push                  = s1_adv && s1_bin_last_reg;
    assign push_data.distance    = sum_sat;
    assign push_data.label       = s1_class_reg;
    assign push_data.skip        = s1_skip_reg;
    assign push_data.last        = s1_sample_last_reg;
    assign push_data.query_class = s1_qclass_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            sum_reg    <= '0;
        end
        else
        begin
            sum_reg <= sum_next;
            if (in_ready)
            begin
                s1_vld_reg <= in_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_sq_reg          <= sq;
            s1_class_reg       <= train_class;
            s1_qclass_reg      <= query_class;
            s1_bin_last_reg    <= bin_last;
            s1_sample_last_reg <= sample_last;
            s1_skip_reg        <= skip_sample;
        end
    end

endmodule

/* rtl/knnhc_fifo.sv */
// ----------------------------------------------------------------------------
// knnhc_fifo
// Two-entry queue of finished samples between the front end and the list
// engine.
// ----------------------------------------------------------------------------
module knnhc_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  knnhc_pkg::event_t   push_data,
    input  logic                pop,
    output knnhc_pkg::event_t   pop_data,
    output logic                full,
    output logic                empty
);

    knnhc_pkg::event_t                     data_reg [knnhc_pkg::FIFO_DEPTH];
    logic [knnhc_pkg::FIFO_PTR_BITS-1:0]   wr_ptr_reg;
    logic [knnhc_pkg::FIFO_PTR_BITS-1:0]   rd_ptr_reg;
    logic [knnhc_pkg::FIFO_CNT_BITS-1:0]   count_reg;
    logic [knnhc_pkg::FIFO_CNT_BITS-1:0]   count_next;

    assign full     = (count_reg == knnhc_pkg::FIFO_CNT_BITS'(knnhc_pkg::FIFO_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = data_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            data_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/knnhc_back.sv */
// ----------------------------------------------------------------------------
// knnhc_back
// List engine: inserts finished samples into the nearest list, tracks the
// largest entry, votes over the classes and drives the result word.
// ----------------------------------------------------------------------------
module knnhc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fifo_empty,
    input  knnhc_pkg::event_t   fifo_data,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [1:0]          predicted_class,
    output logic                keep_query,
    output logic                no_neighbours
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_INSERT,
        S_SCAN,
        S_SCAN_TAIL,
        S_AFTER,
        S_VOTE,
        S_VOTE_TAIL,
        S_DECIDE,
        S_EMIT
    } state_t;

    typedef logic [knnhc_pkg::IDX_BITS-1:0] idx_t;
    typedef logic [knnhc_pkg::CNT_BITS-1:0] cnt_t;

    state_t                 state_reg,  state_next;
    knnhc_pkg::event_t      ev_reg,     ev_next;
    cnt_t                   fill_reg,   fill_next;
    idx_t                   worst_idx_reg,  worst_idx_next;
    knnhc_pkg::dist_t       worst_dist_reg, worst_dist_next;
    idx_t                   rd_idx_reg, rd_idx_next;
    logic                   pipe_vld_reg, pipe_vld_next;
    idx_t                   pipe_idx_reg, pipe_idx_next;
    cnt_t                   votes_reg   [knnhc_pkg::NUM_CLASSES];
    cnt_t                   votes_next  [knnhc_pkg::NUM_CLASSES];
    knnhc_pkg::dist_t       closest_reg [knnhc_pkg::NUM_CLASSES];
    knnhc_pkg::dist_t       closest_next[knnhc_pkg::NUM_CLASSES];
    knnhc_pkg::class_t      cls_idx_reg,    cls_idx_next;
    knnhc_pkg::class_t      best_cls_reg,   best_cls_next;
    cnt_t                   best_votes_reg, best_votes_next;
    knnhc_pkg::dist_t       best_close_reg, best_close_next;
    logic                   out_valid_reg,  out_valid_next;
    knnhc_pkg::class_t      pred_reg,       pred_next;
    logic                   keep_reg,       keep_next;
    logic                   none_reg,       none_next;

    logic                   ram_we;
    idx_t                   ram_waddr;
    knnhc_pkg::entry_t      ram_wdata;
    logic                   ram_re;
    knnhc_pkg::entry_t      ram_rdata;
    logic [knnhc_pkg::ENTRY_BITS-1:0] ram_rdata_raw;

    knnhc_pkg::class_t      cur_cls;
    cnt_t                   cur_votes;
    knnhc_pkg::dist_t       cur_close;

    knnhc_ram #(
        .WIDTH     (knnhc_pkg::ENTRY_BITS),
        .DEPTH     (knnhc_pkg::K_NEIGHBOURS),
        .ADDR_BITS (knnhc_pkg::IDX_BITS)
    ) u_list (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata_raw)
    );

    assign ram_rdata = knnhc_pkg::entry_t'(ram_rdata_raw);
    assign ram_wdata = '{distance: ev_reg.distance, label: ev_reg.label};

    assign cur_cls   = ram_rdata.label;
    assign cur_votes = votes_reg[cls_idx_reg];
    assign cur_close = closest_reg[cls_idx_reg];

    assign out_valid       = out_valid_reg;
    assign predicted_class = pred_reg;
    assign keep_query      = keep_reg;
    assign no_neighbours   = none_reg;

    always_comb
    begin
        state_next      = state_reg;
        ev_next         = ev_reg;
        fill_next       = fill_reg;
        worst_idx_next  = worst_idx_reg;
        worst_dist_next = worst_dist_reg;
        rd_idx_next     = rd_idx_reg;
        pipe_vld_next   = 1'b0;
        pipe_idx_next   = rd_idx_reg;
        votes_next      = votes_reg;
        closest_next    = closest_reg;
        cls_idx_next    = cls_idx_reg;
        best_cls_next   = best_cls_reg;
        best_votes_next = best_votes_reg;
        best_close_next = best_close_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        pred_next       = pred_reg;
        keep_next       = keep_reg;
        none_next       = none_reg;
        pop             = 1'b0;
        ram_we          = 1'b0;
        ram_waddr       = fill_reg[knnhc_pkg::IDX_BITS-1:0];
        ram_re          = 1'b0;

        // The entry read in the previous cycle is folded in here.
        if (pipe_vld_reg && (state_reg == S_SCAN || state_reg == S_SCAN_TAIL))
        begin
            if (pipe_idx_reg == '0 || ram_rdata.distance > worst_dist_reg)
            begin
                worst_dist_next = ram_rdata.distance;
                worst_idx_next  = pipe_idx_reg;
            end
        end
        if (pipe_vld_reg && (state_reg == S_VOTE || state_reg == S_VOTE_TAIL))
        begin
            votes_next[cur_cls] = votes_reg[cur_cls] + 1'b1;
            if (ram_rdata.distance < closest_reg[cur_cls])
            begin
                closest_next[cur_cls] = ram_rdata.distance;
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (!fifo_empty)
                begin
                    pop        = 1'b1;
                    ev_next    = fifo_data;
                    state_next = S_INSERT;
                end
            end
            S_INSERT:
            begin
                state_next = S_AFTER;
                if (!ev_reg.skip)
                begin
                    if (fill_reg < cnt_t'(knnhc_pkg::K_NEIGHBOURS))
                    begin
                        ram_we    = 1'b1;
                        fill_next = fill_reg + 1'b1;
                        // Once the list is full the largest entry must be known.
                        if (fill_reg == cnt_t'(knnhc_pkg::K_NEIGHBOURS - 1))
                        begin
                            rd_idx_next = '0;
                            state_next  = S_SCAN;
                        end
                    end
                    else if (ev_reg.distance < worst_dist_reg)
                    begin
                        ram_we      = 1'b1;
                        ram_waddr   = worst_idx_reg;
                        rd_idx_next = '0;
                        state_next  = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                ram_re        = 1'b1;
                pipe_vld_next = 1'b1;
                if (rd_idx_reg == idx_t'(knnhc_pkg::K_NEIGHBOURS - 1))
                begin
                    state_next = S_SCAN_TAIL;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
            end
            S_SCAN_TAIL:
            begin
                state_next = S_AFTER;
            end
            S_AFTER:
            begin
                if (!ev_reg.last)
                begin
                    state_next = S_IDLE;
                end
                else if (fill_reg == '0)
                begin
                    best_cls_next = '0;
                    state_next    = S_EMIT;
                end
                else
                begin
                    for (int c = 0; c < knnhc_pkg::NUM_CLASSES; c++)
                    begin
                        votes_next[c]   = '0;
                        closest_next[c] = knnhc_pkg::DIST_MAX;
                    end
                    rd_idx_next = '0;
                    state_next  = S_VOTE;
                end
            end
            S_VOTE:
            begin
                ram_re        = 1'b1;
                pipe_vld_next = 1'b1;
                if ((cnt_t'(rd_idx_reg) + cnt_t'(1)) == fill_reg)
                begin
                    state_next = S_VOTE_TAIL;
                end
                else
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                end
            end
            S_VOTE_TAIL:
            begin
                cls_idx_next = '0;
                state_next   = S_DECIDE;
            end
            S_DECIDE:
            begin
                // Most votes wins; a tie goes to the class with the closer neighbor.
                if (cls_idx_reg == '0 || cur_votes > best_votes_reg ||
                    (cur_votes == best_votes_reg && cur_close < best_close_reg))
                begin
                    best_cls_next   = cls_idx_reg;
                    best_votes_next = cur_votes;
                    best_close_next = cur_close;
                end
                if (cls_idx_reg == knnhc_pkg::class_t'(knnhc_pkg::NUM_CLASSES - 1))
                begin
                    state_next = S_EMIT;
                end
                else
                begin
                    cls_idx_next = cls_idx_reg + 1'b1;
                end
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    pred_next      = best_cls_reg;
                    none_next      = (fill_reg == '0);
                    keep_next      = (fill_reg != '0) && (best_cls_reg == ev_reg.query_class);
                    fill_next      = '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            ev_reg         <= '0;
            fill_reg       <= '0;
            worst_idx_reg  <= '0;
            worst_dist_reg <= '0;
            rd_idx_reg     <= '0;
            pipe_vld_reg   <= 1'b0;
            pipe_idx_reg   <= '0;
            for (int c = 0; c < knnhc_pkg::NUM_CLASSES; c++)
            begin
                votes_reg[c]   <= '0;
                closest_reg[c] <= '0;
            end
            cls_idx_reg    <= '0;
            best_cls_reg   <= '0;
            best_votes_reg <= '0;
            best_close_reg <= '0;
            out_valid_reg  <= 1'b0;
            pred_reg       <= '0;
            keep_reg       <= 1'b0;
            none_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ev_reg         <= ev_next;
            fill_reg       <= fill_next;
            worst_idx_reg  <= worst_idx_next;
            worst_dist_reg <= worst_dist_next;
            rd_idx_reg     <= rd_idx_next;
            pipe_vld_reg   <= pipe_vld_next;
            pipe_idx_reg   <= pipe_idx_next;
            votes_reg      <= votes_next;
            closest_reg    <= closest_next;
            cls_idx_reg    <= cls_idx_next;
            best_cls_reg   <= best_cls_next;
            best_votes_reg <= best_votes_next;
            best_close_reg <= best_close_next;
            out_valid_reg  <= out_valid_next;
            pred_reg       <= pred_next;
            keep_reg       <= keep_next;
            none_reg       <= none_next;
        end
    end

endmodule

/* rtl/knn_histogram_classifier_core.sv */
// ----------------------------------------------------------------------------
// knn_histogram_classifier_core
// Nearest-neighbor vote over streamed histogram bin pairs.
// ----------------------------------------------------------------------------
// Each input word carries one query bin and the matching training bin; the
// front end takes one word per cycle unless a word that closes a sample meets
// a full queue, and accumulates the squared difference into a saturating
// 43-bit distance. The word that closes a training sample hands that sample
// to a two-entry queue, and the list engine behind it inserts it into the
// five-entry nearest list (kept in a small RAM, one read per cycle), finds
// the new largest entry, and on the query's last sample votes over the four
// classes (if the list is not empty) and presents one result word. The list
// engine finds the largest entry again by a sequential scan of the list RAM
// when the list fills or an entry is replaced, and adds the vote on the last
// sample of a query; bins within a sample stream at one word per cycle, so
// input stalls only when samples end more often than the engine can drain
// the queue. A result waits in its output register; the engine stalls behind
// it only when the next result is ready before the first one is taken.
// ----------------------------------------------------------------------------
module knn_histogram_classifier_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] query_bin,
    input  logic [15:0] train_bin,
    input  logic [1:0]  train_class,
    input  logic [1:0]  query_class,
    input  logic        bin_last,
    input  logic        sample_last,
    input  logic        skip_sample,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  predicted_class,
    output logic        keep_query,
    output logic        no_neighbours
);

    logic               push;
    knnhc_pkg::event_t  push_data;
    logic               pop;
    knnhc_pkg::event_t  pop_data;
    logic               fifo_full;
    logic               fifo_empty;

    knnhc_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .query_bin   (query_bin),
        .train_bin   (train_bin),
        .train_class (train_class),
        .query_class (query_class),
        .bin_last    (bin_last),
        .sample_last (sample_last),
        .skip_sample (skip_sample),
        .push        (push),
        .push_data   (push_data),
        .fifo_full   (fifo_full)
    );

    knnhc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .pop_data  (pop_data),
        .full      (fifo_full),
        .empty     (fifo_empty)
    );

    knnhc_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .fifo_empty      (fifo_empty),
        .fifo_data       (pop_data),
        .pop             (pop),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .predicted_class (predicted_class),
        .keep_query      (keep_query),
        .no_neighbours   (no_neighbours)
    );

endmodule
